/* design/host_and_email_name_checker_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the host and e-mail name checker
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HOST_AND_EMAIL_NAME_CHECKER_CORE_ASSERT_SVH
`define HOST_AND_EMAIL_NAME_CHECKER_CORE_ASSERT_SVH

// Same-edge implication, disabled while reset is asserted.
`define HECC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hecc assertion failed");

// Next-edge implication, disabled while reset is asserted.
`define HECC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hecc assertion failed");

// Implication checked during reset as well.
`define HECC_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("hecc assertion failed");

`endif

/* design/hecc_pkg.sv */
// ----------------------------------------------------------------------------
// hecc_pkg
// Types and constants shared by the host and e-mail name checker.
// ----------------------------------------------------------------------------
package hecc_pkg;

    // Mode register codes
    localparam logic [1:0] MODE_HOST     = 2'd0;
    localparam logic [1:0] MODE_RFC822   = 2'd1;
    localparam logic [1:0] MODE_SMTPUTF8 = 2'd2;

    // Length limits
    localparam logic [8:0] SAT_COUNT = 9'd321;
    localparam logic [8:0] HOST_MIN  = 9'd2;
    localparam logic [8:0] HOST_MAX  = 9'd256;
    localparam logic [8:0] LOCAL_MAX = 9'd64;
    localparam logic [8:0] EMAIL_MAX = 9'd320;
    localparam logic [6:0] LABEL_MAX = 7'd63;
    localparam logic [6:0] LABEL_SAT = 7'd64;

    // Special characters
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_HYPHEN     = 8'h2D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_AT         = 8'h40;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       is_last;
    } t_in_beat;

    typedef struct packed {
        logic       valid_res;
        logic [8:0] name_length;
    } t_out_beat;

    // Input register contents handed to the scanner
    typedef struct packed {
        logic     valid;
        t_in_beat beat;
    } t_in_stage;

    // Result handed from the scanner to the output register
    typedef struct packed {
        logic      push;
        t_out_beat beat;
    } t_res_push;

endpackage

/* design/hecc_in_stage.sv */
// ----------------------------------------------------------------------------
// hecc_in_stage
// Input register: captures one byte beat and holds it until the scanner takes it.
// ----------------------------------------------------------------------------
module hecc_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hecc_pkg::t_in_beat  i_in_data,
    input  logic                i_advance,
    output hecc_pkg::t_in_stage o_stage
);

    logic               r_valid;
    hecc_pkg::t_in_beat r_beat;
    logic               take;

    assign o_in_ready = !r_valid || i_advance;
    assign take       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload: load on accept, no reset needed
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_beat <= i_in_data;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.beat  = r_beat;

endmodule

/* design/hecc_scan.sv */
// ----------------------------------------------------------------------------
// hecc_scan
// Per-byte scanner: updates counters and flags, forms the verdict on the last byte.
// ----------------------------------------------------------------------------
module hecc_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_mode,
    input  hecc_pkg::t_in_stage i_stage,
    input  logic                i_advance,
    output hecc_pkg::t_res_push o_push
);

    logic [8:0] r_byte_count;
    logic [6:0] r_label_count;
    logic [8:0] r_domain_count;
    logic [8:0] r_local_length;
    logic [7:0] r_previous_byte;
    logic       r_at_seen;
    logic       r_running_nonascii;
    logic       r_local_nonascii;
    logic       r_domain_failed;
    logic       r_nul_failed;

    // State after this byte
    logic [8:0] post_byte_count;
    logic [6:0] post_label_count;
    logic [8:0] post_domain_count;
    logic [8:0] post_local_length;
    logic [7:0] post_previous_byte;
    logic       post_at_seen;
    logic       post_running_nonascii;
    logic       post_local_nonascii;
    logic       post_domain_failed;
    logic       post_nul_failed;

    logic [7:0] c;
    logic       last;
    logic       is_email;
    logic       any_byte;
    logic       fire;
    logic       domain_ok;
    logic       verdict;

    assign c        = i_stage.beat.name_byte;
    assign last     = i_stage.beat.is_last;
    assign is_email = (i_mode == hecc_pkg::MODE_RFC822) || (i_mode == hecc_pkg::MODE_SMTPUTF8);
    assign any_byte = (i_mode == hecc_pkg::MODE_SMTPUTF8);
    assign fire     = i_stage.valid && i_advance;

    always_comb begin
        post_byte_count       = r_byte_count;
        post_label_count      = r_label_count;
        post_domain_count     = r_domain_count;
        post_local_length     = r_local_length;
        post_previous_byte    = r_previous_byte;
        post_at_seen          = r_at_seen;
        post_running_nonascii = r_running_nonascii;
        post_local_nonascii   = r_local_nonascii;
        post_domain_failed    = r_domain_failed;
        post_nul_failed       = r_nul_failed;

        if (c == 8'h00) begin
            // A trailing NUL is dropped; anywhere else it fails the name
            if (!last) begin
                post_nul_failed = 1'b1;
            end
        end else begin
            post_running_nonascii = r_running_nonascii | c[7];
            if (is_email && (c == hecc_pkg::CH_AT)) begin
                // Restart the domain part at every '@'
                post_at_seen        = 1'b1;
                post_local_length   = r_byte_count;
                post_local_nonascii = r_running_nonascii;
                post_domain_count   = '0;
                post_label_count    = '0;
                post_previous_byte  = '0;
                post_domain_failed  = 1'b0;
            end else begin
                if (c == hecc_pkg::CH_DOT) begin
                    if (((r_label_count == '0) && (r_domain_count != '0)) ||
                        (r_previous_byte == hecc_pkg::CH_HYPHEN)) begin
                        post_domain_failed = 1'b1;
                    end
                    post_label_count = '0;
                end else begin
                    if ((r_label_count == '0) && (c == hecc_pkg::CH_HYPHEN)) begin
                        post_domain_failed = 1'b1;
                    end
                    if (!any_byte && !(c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                                                 hecc_pkg::CH_UNDERSCORE,
                                                 hecc_pkg::CH_HYPHEN})) begin
                        post_domain_failed = 1'b1;
                    end
                    post_label_count = (r_label_count < hecc_pkg::LABEL_SAT) ?
                                       r_label_count + 7'd1 : hecc_pkg::LABEL_SAT;
                    if (post_label_count > hecc_pkg::LABEL_MAX) begin
                        post_domain_failed = 1'b1;
                    end
                end
                post_previous_byte = c;
                post_domain_count  = (r_domain_count < hecc_pkg::SAT_COUNT) ?
                                     r_domain_count + 9'd1 : hecc_pkg::SAT_COUNT;
            end
            post_byte_count = (r_byte_count < hecc_pkg::SAT_COUNT) ?
                              r_byte_count + 9'd1 : hecc_pkg::SAT_COUNT;
        end
    end

    assign domain_ok = !post_domain_failed &&
                       (post_domain_count >= hecc_pkg::HOST_MIN) &&
                       (post_domain_count <= hecc_pkg::HOST_MAX) &&
                       (post_previous_byte != hecc_pkg::CH_DOT) &&
                       (post_previous_byte != hecc_pkg::CH_HYPHEN);

    always_comb begin
        verdict = 1'b0;
        if ((post_byte_count != '0) && !post_nul_failed) begin
            case (i_mode)
                hecc_pkg::MODE_HOST: begin
                    verdict = domain_ok;
                end
                hecc_pkg::MODE_RFC822: begin
                    verdict = domain_ok && post_at_seen && !post_local_nonascii &&
                              (post_byte_count <= hecc_pkg::EMAIL_MAX) &&
                              (post_local_length <= hecc_pkg::LOCAL_MAX);
                end
                hecc_pkg::MODE_SMTPUTF8: begin
                    verdict = domain_ok && post_at_seen && post_local_nonascii &&
                              (post_byte_count <= hecc_pkg::EMAIL_MAX) &&
                              (post_local_length <= hecc_pkg::LOCAL_MAX);
                end
                default: begin
                    verdict = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && last)) begin
            r_byte_count       <= '0;
            r_label_count      <= '0;
            r_domain_count     <= '0;
            r_local_length     <= '0;
            r_previous_byte    <= '0;
            r_at_seen          <= 1'b0;
            r_running_nonascii <= 1'b0;
            r_local_nonascii   <= 1'b0;
            r_domain_failed    <= 1'b0;
            r_nul_failed       <= 1'b0;
        end else if (fire) begin
            r_byte_count       <= post_byte_count;
            r_label_count      <= post_label_count;
            r_domain_count     <= post_domain_count;
            r_local_length     <= post_local_length;
            r_previous_byte    <= post_previous_byte;
            r_at_seen          <= post_at_seen;
            r_running_nonascii <= post_running_nonascii;
            r_local_nonascii   <= post_local_nonascii;
            r_domain_failed    <= post_domain_failed;
            r_nul_failed       <= post_nul_failed;
        end
    end

    assign o_push.push             = fire && last;
    assign o_push.beat.valid_res   = verdict;
    assign o_push.beat.name_length = post_byte_count;

endmodule

/* design/hecc_out_stage.sv */
// ----------------------------------------------------------------------------
// hecc_out_stage
// Result register: holds one verdict beat until the consumer takes it.
// ----------------------------------------------------------------------------
module hecc_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hecc_pkg::t_res_push i_push,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hecc_pkg::t_out_beat o_out_data
);

    logic                r_valid;
    hecc_pkg::t_out_beat r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.push) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_data <= i_push.beat;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

/* design/host_and_email_name_checker_core.sv */
// ----------------------------------------------------------------------------
// host_and_email_name_checker_core: host name / e-mail address checker
// Path: a last byte's beat passes the input register, then the result register, to its result beat.
// Throughput: 1 byte beat per cycle, set by the single scan stage, while no last byte waits on a full result register.
// Reset: synchronous, active low; clears the flags, counters and mode (host).
// ----------------------------------------------------------------------------
//
// A name arrives one byte per input beat; the beat with is_last set closes
// it and produces one result beat (valid_res, name_length). Three registers
// parts form the path:
//   - hecc_in_stage : input register for one byte beat
//   - hecc_scan     : per-name counters and flags, updated by short logic;
//                     the last byte forms the verdict and clears the state
//   - hecc_out_stage: result register toward the consumer
// Only a last-byte beat needs the result register, so the input side keeps
// taking ordinary bytes while a finished result waits to be taken. A last
// byte waits in the input register only while the result register is full
// and not being drained.
//
// Mode register: 0 host name, 1 rfc822 e-mail, 2 smtputf8 e-mail; the
// unused code scans like host mode and always reports invalid.
module host_and_email_name_checker_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hecc_pkg::t_in_beat  i_in_data,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hecc_pkg::t_out_beat o_out_data,
    // mode register write port
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_wdata
);

    logic [1:0]          r_mode;
    hecc_pkg::t_in_stage stage;
    hecc_pkg::t_res_push push;
    logic                out_blocked;
    logic                advance;

    // Mode register; the user must write it only while the block is idle (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= hecc_pkg::MODE_HOST;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // Hold a last byte while the result register cannot take its verdict
    assign out_blocked = o_out_valid && !i_out_ready;
    assign advance     = !(stage.valid && stage.beat.is_last && out_blocked);

    hecc_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_advance  (advance),
        .o_stage    (stage)
    );

    hecc_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_stage   (stage),
        .i_advance (advance),
        .o_push    (push)
    );

    hecc_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* design/hecc_checker.sv */
// ----------------------------------------------------------------------------
// hecc_checker
// Port-level checks on the name checker, attached by bind.
// ----------------------------------------------------------------------------
`include "host_and_email_name_checker_core_assert.svh"

module hecc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input hecc_pkg::t_in_beat  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input hecc_pkg::t_out_beat o_out_data,
    input logic                i_cfg_we,
    input logic [1:0]          i_cfg_wdata
);

    // A stalled result beat holds
    `HECC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // An accepted name lies within the host and e-mail length limits
    `HECC_ASSERT_IMPL(a_valid_len, i_clk, i_rst_n, o_out_valid && o_out_data.valid_res, (o_out_data.name_length >= 9'd2) && (o_out_data.name_length <= 9'd320))

    // A fresh result follows a last-byte beat taken through the input and result registers
    `HECC_ASSERT_IMPL(a_res_cause, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && o_in_ready && i_in_data.is_last, 2))

    // Reset leaves no result pending and the byte side open
    `HECC_ASSERT_ALWAYS(a_reset_idle, i_clk, !$past(i_rst_n), !o_out_valid && o_in_ready)

endmodule

bind host_and_email_name_checker_core hecc_checker u_hecc_checker (.*);

/* test/host_and_email_name_checker_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_and_email_name_checker_core_tb: host name and e-mail name checker test
// Streams names one byte beat at a time under each mode, mirrors the scan in
// a scoreboard and compares every result beat with its predicted verdict.
// ----------------------------------------------------------------------------
import hecc_pkg::*;

class name_verdict_board;
    logic [1:0] mode;
    logic [8:0] byte_cnt;
    logic [8:0] dom_cnt;
    logic [8:0] local_bytes;
    logic [6:0] label_cnt;
    logic [7:0] prev_byte;
    bit         at_seen;
    bit         any_high;
    bit         local_high;
    bit         dom_bad;
    bit         nul_bad;
    t_out_beat  verdicts_due[$];
    int         mismatches;

    function new();
        mode       = MODE_HOST;
        mismatches = 0;
        clear();
    endfunction

    function void clear();
        byte_cnt    = '0;
        dom_cnt     = '0;
        local_bytes = '0;
        label_cnt   = '0;
        prev_byte   = '0;
        at_seen     = 0;
        any_high    = 0;
        local_high  = 0;
        dom_bad     = 0;
        nul_bad     = 0;
    endfunction

    function int pending();
        return verdicts_due.size();
    endfunction

    // Scan one non-NUL byte under the current mode.
    function void take_byte(logic [7:0] c);
        bit label_char;
        label_char = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                     (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDERSCORE || c == CH_HYPHEN;
        if (c[7])
            any_high = 1;
        if ((mode == MODE_RFC822 || mode == MODE_SMTPUTF8) && c == CH_AT) begin
            // last '@' so far: restart the domain part
            at_seen     = 1;
            local_bytes = byte_cnt;
            local_high  = any_high;
            dom_cnt     = '0;
            label_cnt   = '0;
            prev_byte   = '0;
            dom_bad     = 0;
        end else begin
            if (c == CH_DOT) begin
                if (label_cnt == 0 && dom_cnt != 0)
                    dom_bad = 1;
                if (prev_byte == CH_HYPHEN)
                    dom_bad = 1;
                label_cnt = '0;
            end else begin
                if (label_cnt == 0 && c == CH_HYPHEN)
                    dom_bad = 1;
                if (mode != MODE_SMTPUTF8 && !label_char)
                    dom_bad = 1;
                label_cnt = (label_cnt < LABEL_SAT) ? label_cnt + 7'd1 : LABEL_SAT;
                if (label_cnt > LABEL_MAX)
                    dom_bad = 1;
            end
            prev_byte = c;
            dom_cnt   = (dom_cnt < SAT_COUNT) ? dom_cnt + 9'd1 : SAT_COUNT;
        end
        byte_cnt = (byte_cnt < SAT_COUNT) ? byte_cnt + 9'd1 : SAT_COUNT;
    endfunction

    // Note an accepted byte beat; a last beat queues its verdict.
    function void note_byte(t_in_beat beat);
        bit        host_ok;
        bit        email_ok;
        t_out_beat want;
        if (!beat.is_last) begin
            if (beat.name_byte == 8'h00)
                nul_bad = 1;
            else
                take_byte(beat.name_byte);
            return;
        end
        if (beat.name_byte != 8'h00)
            take_byte(beat.name_byte);
        host_ok  = !dom_bad && dom_cnt >= HOST_MIN && dom_cnt <= HOST_MAX &&
                   prev_byte != CH_DOT && prev_byte != CH_HYPHEN;
        email_ok = at_seen && byte_cnt <= EMAIL_MAX && local_bytes <= LOCAL_MAX && host_ok;
        case (mode)
            MODE_HOST:     want.valid_res = host_ok;
            MODE_RFC822:   want.valid_res = email_ok && !local_high;
            MODE_SMTPUTF8: want.valid_res = email_ok && local_high;
            default:       want.valid_res = 1'b0;
        endcase
        if (byte_cnt == 0 || nul_bad)
            want.valid_res = 1'b0;
        want.name_length = byte_cnt;
        verdicts_due.push_back(want);
        clear();
    endfunction

    function void check_verdict(t_out_beat got);
        t_out_beat want;
        if (verdicts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: valid_res=%0d name_length=%0d",
                         got.valid_res, got.name_length);
            return;
        end
        want = verdicts_due.pop_front();
        if (got.valid_res !== want.valid_res || got.name_length !== want.name_length) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected valid_res=%0d name_length=%0d, got valid_res=%0d name_length=%0d",
                         want.valid_res, want.name_length, got.valid_res, got.name_length);
        end
    endfunction
endclass

module host_and_email_name_checker_core_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_beat   i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_beat  o_out_data;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_wdata = 2'd0;

    name_verdict_board board;
    logic [7:0]        name_buf[$];
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    int                rx_hold_req = 0;

    // Phase plan: three idling stages, each across several modes. A nonzero
    // long length closes the phase with one large name.
    logic [1:0] phase_mode [9] = '{MODE_HOST, MODE_RFC822, MODE_SMTPUTF8,
                                   MODE_SMTPUTF8, MODE_UNUSED, MODE_RFC822,
                                   MODE_RFC822, MODE_HOST, MODE_SMTPUTF8};
    int         phase_tx   [9] = '{20, 20, 20, 62, 62, 62, 0, 0, 0};
    int         phase_rx   [9] = '{62, 62, 62, 20, 20, 20, 0, 0, 0};
    int         phase_long [9] = '{0, 0, 0, 65, 0, 0, 330, 0, 0};

    host_and_email_name_checker_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Name generation into name_buf
    // ------------------------------------------------------------------

    // Mostly label characters; non-ASCII bytes only when asked for.
    function automatic logic [7:0] label_byte(bit utf8);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'(8'h61 + $urandom_range(0, 25));
            4:          return 8'(8'h41 + $urandom_range(0, 25));
            5:          return 8'(8'h30 + $urandom_range(0, 9));
            6:          return CH_UNDERSCORE;
            7:          return CH_HYPHEN;
            default:    return utf8 ? 8'($urandom_range(128, 255))
                                    : 8'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    // Keep most hyphens off the label edges so that well-formed names dominate.
    function automatic void add_label(int n, bit utf8);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c = label_byte(utf8);
            if ((i == 0 || i == n - 1) && c == CH_HYPHEN && $urandom_range(0, 3) != 0)
                c = 8'h6B;
            name_buf.push_back(c);
        end
    endfunction

    function automatic void add_domain(int len, bit utf8, int max_label);
        int left;
        int n;
        left = len;
        if (left > 1 && $urandom_range(0, 9) == 0) begin
            name_buf.push_back(CH_DOT);
            left--;
        end
        while (left > 0) begin
            n = $urandom_range(1, max_label);
            if (n > left)
                n = left;
            add_label(n, utf8);
            left -= n;
            if (left > 0) begin
                name_buf.push_back(CH_DOT);
                left--;
            end
        end
    endfunction

    // Printable ASCII local part; one non-ASCII byte when utf8 is set.
    function automatic void add_local(int n, bit utf8);
        int high_at;
        high_at = (utf8 && n > 0) ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n; i++)
            name_buf.push_back(i == high_at ? 8'($urandom_range(128, 255))
                                            : 8'($urandom_range(33, 126)));
    endfunction

    // Build one name for mode m; total of zero gives a short random one.
    function automatic void build_name(logic [1:0] m, int total);
        int loc;
        int dom_len;
        bit utf8;
        bit email_form;
        name_buf.delete();
        if (total == 0 && $urandom_range(0, 9) == 0) begin
            // noise: raw bytes of any value
            repeat ($urandom_range(1, 6))
                name_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        utf8 = (m == MODE_SMTPUTF8);
        if ($urandom_range(0, 7) == 0)
            utf8 = !utf8;
        email_form = (m == MODE_RFC822 || m == MODE_SMTPUTF8);
        if ($urandom_range(0, 9) == 0)
            email_form = !email_form;
        if (email_form) begin
            if (total != 0)
                loc = 62 + $urandom_range(0, 3);
            else begin
                case ($urandom_range(0, 9))
                    0:       loc = 0;
                    1:       loc = 63 + $urandom_range(0, 2);
                    default: loc = $urandom_range(1, 10);
                endcase
            end
            add_local(loc, utf8);
            name_buf.push_back(CH_AT);
            if ($urandom_range(0, 9) == 0) begin
                // a second '@' moves the split point
                add_local(2, 1'b0);
                name_buf.push_back(CH_AT);
            end
            dom_len = (total != 0) ? total - loc - 1 : $urandom_range(1, 20);
            if (dom_len < 1)
                dom_len = 1;
            add_domain(dom_len, utf8, total != 0 ? 63 + $urandom_range(0, 2) : 8);
        end else begin
            add_domain(total != 0 ? total : $urandom_range(1, 24), utf8,
                       total != 0 ? 63 + $urandom_range(0, 2) : 8);
        end
        // break a well-formed name now and then
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 4))
                0: name_buf[$urandom_range(0, name_buf.size() - 1)] = CH_DOT;
                1: name_buf[$urandom_range(0, name_buf.size() - 1)] = CH_HYPHEN;
                2: name_buf[$urandom_range(0, name_buf.size() - 1)] = CH_AT;
                3: name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'h00;
                default: name_buf[$urandom_range(0, name_buf.size() - 1)] =
                             8'($urandom_range(0, 255));
            endcase
        end
        if ($urandom_range(0, 7) == 0)
            name_buf.push_back(8'h00);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one byte beat, idling first at random; hold valid and payload
    // until the beat is taken. Valid stays high on return.
    task automatic send_beat(t_in_beat beat);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        board.note_byte(beat);
    endtask

    // Stream name_buf, flagging its final byte as last.
    task automatic send_name();
        t_in_beat beat;
        for (int i = 0; i < name_buf.size(); i++) begin
            beat.name_byte = name_buf[i];
            beat.is_last   = (i == name_buf.size() - 1);
            send_beat(beat);
        end
    endtask

    // Drain every pending verdict, let the scan settle, then write the mode.
    task automatic set_mode(logic [1:0] m);
        i_in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.mode = m;
    endtask

    // ------------------------------------------------------------------
    // Result side: check each taken beat, then pick the next ready level.
    // A requested hold drops ready for a long stretch so that the result
    // register fills and the block holds the next last byte at its input.
    // ------------------------------------------------------------------
    initial begin : result_side
        int hold_left;
        int hold_done;
        hold_left = 0;
        hold_done = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                board.check_verdict(o_out_data);
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_done != rx_hold_req) begin
                hold_done++;
                hold_left = 300;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : byte_side
        int sent;
        int names;
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed host names under the reset mode: lone NUL, single byte,
        // embedded NUL, dropped trailing NUL, leading hyphen, bad byte after
        // a leading dot, trailing dot, then a clean name with a leading dot.
        name_buf = '{8'h00};                       send_name();
        name_buf = '{8'h61};                       send_name();
        name_buf = '{8'h61, 8'h00, 8'h62};         send_name();
        name_buf = '{8'h61, 8'h62, 8'h00};         send_name();
        name_buf = '{CH_HYPHEN, 8'h61};            send_name();
        name_buf = '{CH_DOT, 8'h61, 8'hFF};        send_name();
        name_buf = '{8'h61, CH_DOT};               send_name();
        name_buf = '{CH_DOT, 8'h61, CH_UNDERSCORE}; send_name();

        // Directed e-mail: plain ASCII, then a non-ASCII local part with
        // non-ASCII domain bytes.
        set_mode(MODE_RFC822);
        name_buf = '{8'h61, CH_AT, 8'h62, 8'h63};  send_name();
        set_mode(MODE_SMTPUTF8);
        name_buf = '{8'hC3, CH_AT, 8'h80, 8'hFF};  send_name();

        // Random phases; set_mode also waits until every verdict is back.
        // Phases with a receiver hold send at least three names so that a
        // second last byte backs up behind the held result.
        for (int p = 0; p < 9; p++) begin
            tx_idle_pct = phase_tx[p];
            rx_idle_pct = phase_rx[p];
            set_mode(phase_mode[p]);
            if (p == 1 || p == 6)
                rx_hold_req++;
            sent  = 0;
            names = 0;
            while (sent < 16 || ((p == 1 || p == 6) && names < 3)) begin
                build_name(phase_mode[p], 0);
                sent += name_buf.size();
                names++;
                send_name();
            end
            if (phase_long[p] != 0) begin
                build_name(phase_mode[p], phase_long[p]);
                send_name();
            end
        end

        // Drain, then allow the pipeline latency before judging.
        i_in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
